// ===== sv/spt_pkg.sv =====
// ----------------------------------------------------------------------------
// spt_pkg
// Shared constants for the step-toward-target pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package spt_pkg;

    // Width of one signed fixed-point coordinate
    localparam int COORD_WIDTH = 24;

endpackage

`default_nettype wire

// ===== sv/spt_if.sv =====
// ----------------------------------------------------------------------------
// spt interfaces
// Valid/ready channels for point requests and updated points.
// ----------------------------------------------------------------------------
`default_nettype none

interface spt_req_if #(
    parameter int COORD_WIDTH = spt_pkg::COORD_WIDTH
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] cur_x;
    logic signed [COORD_WIDTH-1:0] cur_y;
    logic signed [COORD_WIDTH-1:0] target_x;
    logic signed [COORD_WIDTH-1:0] target_y;
    logic        [COORD_WIDTH-2:0] step_len;

    modport source (output valid, cur_x, cur_y, target_x, target_y, step_len, input ready);
    modport sink   (input valid, cur_x, cur_y, target_x, target_y, step_len, output ready);
endinterface

interface spt_rsp_if #(
    parameter int COORD_WIDTH = spt_pkg::COORD_WIDTH
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] new_x;
    logic signed [COORD_WIDTH-1:0] new_y;
    logic                          arrived;

    modport source (output valid, new_x, new_y, arrived, input ready);
    modport sink   (input valid, new_x, new_y, arrived, output ready);
endinterface

`default_nettype wire

// ===== sv/spt_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// spt_sqrt_cell
// One bit of a pipelined integer square root; passes context along.
// ----------------------------------------------------------------------------
`default_nettype none

module spt_sqrt_cell #(
    parameter int NW      = 50,
    parameter int BIT_POS = 0,
    parameter int CW      = 174
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          en,
    input  wire logic          v_in,
    input  wire logic [NW-1:0] n_in,
    input  wire logic [NW-1:0] root_in,
    input  wire logic [CW-1:0] ctx_in,
    output logic               v_out,
    output logic      [NW-1:0] n_out,
    output logic      [NW-1:0] root_out,
    output logic      [CW-1:0] ctx_out
);

    localparam logic [NW-1:0] BitVal = {{(NW-1){1'b0}}, 1'b1} << (2 * BIT_POS);

    logic [NW-1:0] trial;
    logic          take;
    logic [NW-1:0] n_next;
    logic [NW-1:0] root_next;

    always_comb
    begin
        trial     = root_in + BitVal;
        take      = (n_in >= trial);
        n_next    = take ? (n_in - trial) : n_in;
        root_next = take ? ((root_in >> 1) + BitVal) : (root_in >> 1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_out <= 1'b0;
        end
        else if (en)
        begin
            v_out <= v_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_out    <= n_next;
            root_out <= root_next;
            ctx_out  <= ctx_in;
        end
    end

endmodule

`default_nettype wire

// ===== sv/spt_div_cell.sv =====
// ----------------------------------------------------------------------------
// spt_div_cell
// One quotient bit of two pipelined restoring divisions sharing a divisor.
// ----------------------------------------------------------------------------
`default_nettype none

module spt_div_cell #(
    parameter int NW = 50,
    parameter int QW = 25,
    parameter int K  = 0,
    parameter int CW = 174
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          en,
    input  wire logic          v_in,
    input  wire logic [NW-1:0] remx_in,
    input  wire logic [NW-1:0] remy_in,
    input  wire logic [QW-1:0] qx_in,
    input  wire logic [QW-1:0] qy_in,
    input  wire logic [QW-1:0] mag_in,
    input  wire logic [CW-1:0] ctx_in,
    output logic               v_out,
    output logic      [NW-1:0] remx_out,
    output logic      [NW-1:0] remy_out,
    output logic      [QW-1:0] qx_out,
    output logic      [QW-1:0] qy_out,
    output logic      [QW-1:0] mag_out,
    output logic      [CW-1:0] ctx_out
);

    localparam logic [QW-1:0] QBit = {{(QW-1){1'b0}}, 1'b1} << K;

    logic [NW-1:0] dsh;
    logic          takex;
    logic          takey;

    always_comb
    begin
        dsh   = {{(NW-QW){1'b0}}, mag_in} << K;
        takex = (remx_in >= dsh);
        takey = (remy_in >= dsh);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_out <= 1'b0;
        end
        else if (en)
        begin
            v_out <= v_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            remx_out <= takex ? (remx_in - dsh) : remx_in;
            remy_out <= takey ? (remy_in - dsh) : remy_in;
            qx_out   <= takex ? (qx_in | QBit) : qx_in;
            qy_out   <= takey ? (qy_in | QBit) : qy_in;
            mag_out  <= mag_in;
            ctx_out  <= ctx_in;
        end
    end

endmodule

`default_nettype wire

// ===== sv/step_point_toward_target.sv =====
// ----------------------------------------------------------------------------
// step_point_toward_target
// Moves a fixed-point 2D point one step of given length toward a target.
// ----------------------------------------------------------------------------
// Fully pipelined: one transaction is accepted every cycle while the output
// is not stalled, and each result passes through 3 front stages, one
// square-root cell per root bit, a scaling multiply stage, one divider cell
// per quotient bit, and the output register. The whole pipe advances when
// the output register is empty or being taken, so a stalled result holds
// every stage and request ready follows that same condition.
`default_nettype none

module step_point_toward_target #(
    parameter int COORD_WIDTH = spt_pkg::COORD_WIDTH
) (
    input wire logic clk,
    input wire logic rst_n,
    spt_req_if.sink   req,
    spt_rsp_if.source rsp
);

    localparam int W  = COORD_WIDTH;
    localparam int DW = W + 1;
    localparam int EW = W + 2;
    localparam int NW = 2 * W + 2;
    localparam int CW = 7 * W + 6;
    localparam int P_AY = 5;
    localparam int P_AX = P_AY + DW;
    localparam int P_ST = P_AX + DW;
    localparam int P_TY = P_ST + W - 1;
    localparam int P_TX = P_TY + W;
    localparam int P_CY = P_TX + W;
    localparam int P_CX = P_CY + W;

    logic en;

    // front stage 0: differences
    logic                 s0_v_reg;
    logic signed [W-1:0]  cx_reg, cy_reg, tx_reg, ty_reg;
    logic        [W-2:0]  step_reg;
    logic signed [DW-1:0] dx_reg, dy_reg;
    logic        [DW-1:0] ax, ay;

    // front stage 1: squares
    logic                s1_v_reg;
    logic [NW-1:0]       sqx_reg, sqy_reg;
    logic [2*W-3:0]      ss_reg;
    logic [CW-2:0]       s1_ctx_reg;

    // front stage 2: sum and arrival test
    logic                s2_v_reg;
    logic [NW-1:0]       sum_reg;
    logic [CW-1:0]       s2_ctx_reg;
    logic [NW-1:0]       sum;

    logic          sq_v   [0:DW];
    logic [NW-1:0] sq_n   [0:DW];
    logic [NW-1:0] sq_r   [0:DW];
    logic [CW-1:0] sq_ctx [0:DW];

    // scaling stage
    logic          m_v_reg;
    logic [NW-1:0] numx_reg, numy_reg;
    logic [DW-1:0] mag_reg;
    logic [CW-1:0] m_ctx_reg;
    logic [DW-1:0] mag;
    logic [DW-1:0] cax, cay;
    logic [W-2:0]  cstep;

    logic          dv_v   [0:DW];
    logic [NW-1:0] dv_rx  [0:DW];
    logic [NW-1:0] dv_ry  [0:DW];
    logic [DW-1:0] dv_qx  [0:DW];
    logic [DW-1:0] dv_qy  [0:DW];
    logic [DW-1:0] dv_mag [0:DW];
    logic [CW-1:0] dv_ctx [0:DW];

    // output register
    logic                o_v_reg;
    logic signed [W-1:0] o_x_reg, o_y_reg;
    logic                o_arr_reg;
    logic signed [W-1:0] o_x_next, o_y_next;

    logic [CW-1:0]        fc;
    logic signed [EW-1:0] fcx, fcy, fstep, fqx, fqy;
    logic                 f_arr, f_zx, f_zy, f_nx, f_ny;

    assign en        = !o_v_reg || rsp.ready;
    assign req.ready = en;

    always_comb
    begin
        ax  = dx_reg[DW-1] ? DW'(-dx_reg) : DW'(dx_reg);
        ay  = dy_reg[DW-1] ? DW'(-dy_reg) : DW'(dy_reg);
        sum = sqx_reg + sqy_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_v_reg <= 1'b0;
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
        end
        else if (en)
        begin
            s0_v_reg <= req.valid;
            s1_v_reg <= s0_v_reg;
            s2_v_reg <= s1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cx_reg   <= req.cur_x;
            cy_reg   <= req.cur_y;
            tx_reg   <= req.target_x;
            ty_reg   <= req.target_y;
            step_reg <= req.step_len;
            dx_reg   <= {req.target_x[W-1], req.target_x} - {req.cur_x[W-1], req.cur_x};
            dy_reg   <= {req.target_y[W-1], req.target_y} - {req.cur_y[W-1], req.cur_y};

            sqx_reg    <= NW'(ax * ax);
            sqy_reg    <= NW'(ay * ay);
            ss_reg     <= (2*W-2)'(step_reg * step_reg);
            s1_ctx_reg <= {cx_reg, cy_reg, tx_reg, ty_reg, step_reg, ax, ay,
                           dx_reg[DW-1], dy_reg[DW-1], (dx_reg == '0), (dy_reg == '0)};

            sum_reg    <= sum;
            s2_ctx_reg <= {s1_ctx_reg, (sum <= {2'b00, ss_reg})};
        end
    end

    assign sq_v[0]   = s2_v_reg;
    assign sq_n[0]   = sum_reg;
    assign sq_r[0]   = '0;
    assign sq_ctx[0] = s2_ctx_reg;

    for (genvar i = 0; i < DW; i++)
    begin : g_sqrt
        spt_sqrt_cell #(
            .NW      (NW),
            .BIT_POS (W - i),
            .CW      (CW)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .v_in     (sq_v[i]),
            .n_in     (sq_n[i]),
            .root_in  (sq_r[i]),
            .ctx_in   (sq_ctx[i]),
            .v_out    (sq_v[i+1]),
            .n_out    (sq_n[i+1]),
            .root_out (sq_r[i+1]),
            .ctx_out  (sq_ctx[i+1])
        );
    end

    always_comb
    begin
        mag   = sq_r[DW][DW-1:0];
        cax   = sq_ctx[DW][P_AX +: DW];
        cay   = sq_ctx[DW][P_AY +: DW];
        cstep = sq_ctx[DW][P_ST +: W-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_v_reg <= 1'b0;
        end
        else if (en)
        begin
            m_v_reg <= sq_v[DW];
        end
    end

    // round to nearest: add half the magnitude before dividing
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            numx_reg  <= NW'(cax * cstep) + NW'(mag >> 1);
            numy_reg  <= NW'(cay * cstep) + NW'(mag >> 1);
            mag_reg   <= mag;
            m_ctx_reg <= sq_ctx[DW];
        end
    end

    assign dv_v[0]   = m_v_reg;
    assign dv_rx[0]  = numx_reg;
    assign dv_ry[0]  = numy_reg;
    assign dv_qx[0]  = '0;
    assign dv_qy[0]  = '0;
    assign dv_mag[0] = mag_reg;
    assign dv_ctx[0] = m_ctx_reg;

    for (genvar i = 0; i < DW; i++)
    begin : g_div
        spt_div_cell #(
            .NW (NW),
            .QW (DW),
            .K  (W - i),
            .CW (CW)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .v_in     (dv_v[i]),
            .remx_in  (dv_rx[i]),
            .remy_in  (dv_ry[i]),
            .qx_in    (dv_qx[i]),
            .qy_in    (dv_qy[i]),
            .mag_in   (dv_mag[i]),
            .ctx_in   (dv_ctx[i]),
            .v_out    (dv_v[i+1]),
            .remx_out (dv_rx[i+1]),
            .remy_out (dv_ry[i+1]),
            .qx_out   (dv_qx[i+1]),
            .qy_out   (dv_qy[i+1]),
            .mag_out  (dv_mag[i+1]),
            .ctx_out  (dv_ctx[i+1])
        );
    end

    always_comb
    begin
        fc    = dv_ctx[DW];
        f_arr = fc[0];
        f_zy  = fc[1];
        f_zx  = fc[2];
        f_ny  = fc[3];
        f_nx  = fc[4];
        fcx   = EW'($signed(fc[P_CX +: W]));
        fcy   = EW'($signed(fc[P_CY +: W]));
        fstep = $signed({3'b000, fc[P_ST +: W-1]});
        fqx   = $signed({1'b0, dv_qx[DW]});
        fqy   = $signed({1'b0, dv_qy[DW]});

        if (f_arr)
        begin
            o_x_next = $signed(fc[P_TX +: W]);
            o_y_next = $signed(fc[P_TY +: W]);
        end
        else if (f_zy)
        begin
            // purely horizontal: move x by the full step
            o_x_next = W'(f_nx ? (fcx - fstep) : (fcx + fstep));
            o_y_next = W'(fcy);
        end
        else if (f_zx)
        begin
            o_x_next = W'(fcx);
            o_y_next = W'(f_ny ? (fcy - fstep) : (fcy + fstep));
        end
        else
        begin
            o_x_next = W'(f_nx ? (fcx - fqx) : (fcx + fqx));
            o_y_next = W'(f_ny ? (fcy - fqy) : (fcy + fqy));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_v_reg <= 1'b0;
        end
        else if (en)
        begin
            o_v_reg <= dv_v[DW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            o_x_reg   <= o_x_next;
            o_y_reg   <= o_y_next;
            o_arr_reg <= f_arr;
        end
    end

    assign rsp.valid   = o_v_reg;
    assign rsp.new_x   = o_x_reg;
    assign rsp.new_y   = o_y_reg;
    assign rsp.arrived = o_arr_reg;

    // a stalled result stays put and freezes the pipe
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        o_v_reg && !rsp.ready |=> o_v_reg && $stable(o_x_reg) && $stable(o_y_reg))
        else $error("output changed while stalled");

    // diagonal moves never exceed the distance on either axis
    a_qbound: assert property (@(posedge clk) disable iff (!rst_n)
        dv_v[DW] && !f_arr && !f_zx && !f_zy |->
            dv_qx[DW] <= fc[P_AX +: DW] && dv_qy[DW] <= fc[P_AY +: DW])
        else $error("scaled offset past target");

    // not arrived implies magnitude at least the step
    a_mag: assert property (@(posedge clk) disable iff (!rst_n)
        sq_v[DW] && !sq_ctx[DW][0] |-> mag >= {2'b00, cstep})
        else $error("root below step length");

endmodule

`default_nettype wire

// ===== dv/step_point_toward_target_checker.sv =====
// ----------------------------------------------------------------------------
// step_point_toward_target_checker
// Watches the request and response channels, predicts each updated point
// and compares it field by field with what the pipeline returns.
// ----------------------------------------------------------------------------
`default_nettype none

module step_point_toward_target_checker (
    input wire logic clk,
    input wire logic rst_n,
    spt_req_if.sink  req,
    spt_rsp_if.sink  rsp,
    output int       fail_count,
    output int       pending_points
);
    localparam int W = spt_pkg::COORD_WIDTH;

    typedef struct packed {
        logic signed [W-1:0] px;
        logic signed [W-1:0] py;
        logic                snapped;
    } point_t;

    point_t expected_points[$];

    function automatic longint unsigned root_floor(longint unsigned n);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n)
            b >>= 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint scale_axis(longint d, longint unsigned stp,
                                          longint unsigned m);
        longint unsigned a;
        longint unsigned q;
        a = (d < 0) ? longint'(-d) : longint'(d);
        q = (a * stp + (m >> 1)) / m;
        return (d < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic point_t predict_step(longint cx, longint cy, longint tx,
                                            longint ty, longint unsigned stp);
        point_t p;
        longint dx;
        longint dy;
        longint nx;
        longint ny;
        longint unsigned sq;
        longint unsigned m;
        dx = tx - cx;
        dy = ty - cy;
        sq = longint'(dx * dx) + longint'(dy * dy);
        nx = cx;
        ny = cy;
        p.snapped = 1'b0;
        if (sq <= stp * stp)
        begin
            nx = tx;
            ny = ty;
            p.snapped = 1'b1;
        end
        else if (dy == 0)
            nx = (dx > 0) ? cx + longint'(stp) : cx - longint'(stp);
        else if (dx == 0)
            ny = (dy > 0) ? cy + longint'(stp) : cy - longint'(stp);
        else
        begin
            m = root_floor(sq);
            nx = cx + scale_axis(dx, stp, m);
            ny = cy + scale_axis(dy, stp, m);
        end
        p.px = nx[W-1:0];
        p.py = ny[W-1:0];
        return p;
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch: %s", what);
        fail_count++;
    endtask

    assign pending_points = expected_points.size();

    initial fail_count = 0;

    always @(posedge clk)
    begin
        point_t e;
        if (rst_n && req.valid && req.ready)
            expected_points.push_back(predict_step(longint'(req.cur_x), longint'(req.cur_y),
                longint'(req.target_x), longint'(req.target_y),
                longint'({1'b0, req.step_len})));
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (expected_points.size() == 0)
                report_mismatch("response with no request outstanding");
            else
            begin
                e = expected_points.pop_front();
                if (rsp.new_x !== e.px)
                    report_mismatch($sformatf("new_x %0d want %0d", rsp.new_x, e.px));
                if (rsp.new_y !== e.py)
                    report_mismatch($sformatf("new_y %0d want %0d", rsp.new_y, e.py));
                if (rsp.arrived !== e.snapped)
                    report_mismatch($sformatf("arrived %0b want %0b", rsp.arrived, e.snapped));
            end
        end
    end
endmodule

`default_nettype wire

// ===== dv/step_point_toward_target_test.sv =====
// ----------------------------------------------------------------------------
// step_point_toward_target_test
// Drives directed and random point requests through several idle and stall
// phases; the checker predicts and compares every updated point.
// ----------------------------------------------------------------------------
`default_nettype none

module step_point_toward_target_test;
    localparam int W = spt_pkg::COORD_WIDTH;
    localparam int MAXC = (1 << (W - 1)) - 1;
    localparam int MINC = -(1 << (W - 1));
    localparam int DRAIN = 2 * W + 20;
    localparam int LIMIT = 400000;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending_points;
    int   cycle_count;
    int   idle_pct;
    int   stall_pct;

    spt_req_if req ();
    spt_rsp_if rsp ();

    step_point_toward_target dut (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp));

    step_point_toward_target_checker chk (
        .clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp),
        .fail_count(fail_count), .pending_points(pending_points)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > LIMIT)
            begin
                $display("step_point_toward_target_test NOT OK");
                $finish;
            end
        end
    end

    // random backpressure on the result side
    always @(negedge clk)
        rsp.ready <= ($urandom_range(99) >= stall_pct);

    function automatic int rand_coord();
        case ($urandom_range(3))
            0: return $urandom_range(1) ? MAXC : MINC;
            1: return $urandom_range(2000) - 1000;
            default: return int'({{(32 - W){1'b0}}, W'($urandom)} << (32 - W)) >>> (32 - W);
        endcase
    endfunction

    // leave valid high after the transaction; the next call or the caller drops it
    task automatic send_point(input int cx, input int cy, input int tx, input int ty,
                              input int stp);
        while ($urandom_range(99) < idle_pct)
        begin
            req.valid <= 1'b0;
            @(negedge clk);
        end
        req.valid    <= 1'b1;
        req.cur_x    <= cx[W-1:0];
        req.cur_y    <= cy[W-1:0];
        req.target_x <= tx[W-1:0];
        req.target_y <= ty[W-1:0];
        req.step_len <= stp[W-2:0];
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_random();
        int cx;
        int cy;
        int dx;
        int dy;
        int stp;
        cx = rand_coord();
        cy = rand_coord();
        case ($urandom_range(5))
            0: begin dx = $urandom_range(4000) - 2000; dy = 0; end
            1: begin dx = 0; dy = $urandom_range(4000) - 2000; end
            2: begin dx = $urandom_range(600) - 300; dy = $urandom_range(600) - 300; end
            default: begin dx = rand_coord(); dy = rand_coord(); end
        endcase
        // keep the target in range
        if (longint'(cx) + dx > MAXC || longint'(cx) + dx < MINC) dx = -dx;
        if (longint'(cy) + dy > MAXC || longint'(cy) + dy < MINC) dy = -dy;
        case ($urandom_range(3))
            0: stp = $urandom_range(500);
            1: stp = MAXC;
            default: stp = $urandom & MAXC;
        endcase
        send_point(cx, cy, cx + dx, cy + dy, stp);
    endtask

    initial
    begin
        req.valid    = 1'b0;
        req.cur_x    = '0;
        req.cur_y    = '0;
        req.target_x = '0;
        req.target_y = '0;
        req.step_len = '0;
        rsp.ready    = 1'b0;
        idle_pct     = 0;
        stall_pct    = 0;
        rst_n        = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // already at target, exact arrival, axis moves, corners, diagonals
        send_point(0, 0, 0, 0, 0);
        send_point(100, 100, 100, 100, MAXC);
        send_point(0, 0, 3, 4, 5);
        send_point(0, 0, 3, 4, 4);
        send_point(0, 0, 1000, 0, 10);
        send_point(0, 0, -1000, 0, 10);
        send_point(0, 0, 0, 1000, 10);
        send_point(0, 0, 0, -1000, 10);
        send_point(MINC, MINC, MAXC, MAXC, MAXC);
        send_point(MAXC, MAXC, MINC, MINC, 1);
        send_point(MINC, MAXC, MAXC, MINC, 12345);
        send_point(MAXC, MINC, MINC, MAXC, 0);
        send_point(MINC, 0, MAXC, 0, MAXC);
        send_point(0, MAXC, 0, MINC, MAXC);
        send_point(0, 0, 1, 1, 1);
        send_point(0, 0, 1, 1, 0);
        send_point(-5, 7, 2, -3, 3);
        send_point(10, 10, 13, 11, 2);
        send_point(0, 0, -1, 2, 1);

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 50; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 50; end
                default: begin idle_pct = 29; stall_pct = 29; end
            endcase
            repeat (300) send_random();
        end
        req.valid <= 1'b0;

        while (pending_points != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
        if (fail_count == 0)
            $display("step_point_toward_target_test OK");
        else
            $display("step_point_toward_target_test NOT OK");
        $finish;
    end
endmodule

`default_nettype wire

// ===== filelist.f =====
sv/spt_pkg.sv
sv/spt_if.sv
sv/spt_sqrt_cell.sv
sv/spt_div_cell.sv
sv/step_point_toward_target.sv
dv/step_point_toward_target_checker.sv
dv/step_point_toward_target_test.sv
